// ----- src/pgs_rle_bitmap_decoder_assert.svh -----
// Assertion macros for the PGS RLE bitmap decoder checks.
// Used by the port checker; expects clock aclk and reset aresetn in scope.
`ifndef PGS_RLE_BITMAP_DECODER_ASSERT_SVH
`define PGS_RLE_BITMAP_DECODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("prbd check failed");

// Consequent checked in the cycle after the antecedent.
`define PRBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("prbd check failed");

`endif

// ----- src/prbd_pkg.sv -----
// Shared constants, types and helpers for the PGS RLE bitmap decoder.
// No dependencies; imported by all decoder modules and the checker.
`default_nettype none

package prbd_pkg;

    localparam int DIM_W     = 13;  // width/height register width
    localparam int RUN_W     = 14;
    localparam int IDX_W     = 24;
    localparam int PT_W      = 25;  // pixel count, up to 4096*4096
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_LINE_ERR   = 2'd1;
    localparam logic [1:0] STATUS_SHORT_DATA = 2'd2;

    // escape flags byte layout
    localparam int FLAG_LONG_BIT   = 6;
    localparam int FLAG_COLOUR_BIT = 7;
    localparam int SHORT_RUN_W     = 6;

    // column remainder unit: bits retired per cycle and pass count
    localparam int MOD_STEPS  = 7;
    localparam int MOD_PASSES = (PT_W + MOD_STEPS - 1) / MOD_STEPS;
    localparam int MOD_DIV_W  = MOD_PASSES * MOD_STEPS;
    localparam int MOD_CNT_W  = $clog2(MOD_PASSES + 1);

    typedef struct packed {
        logic load;       // latch the accepted byte
        logic mod_start;  // start column remainder
        logic commit;     // update decode state and result register
    } prbd_cmd_t;

    typedef struct packed {
        logic eol;        // current byte completes an end-of-line code
        logic mod_busy;
        logic have;       // current byte yields a result
        logic out_busy;   // result register full and not taken this cycle
    } prbd_sts_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/prbd_ctrl.sv -----
// Sequencer of the PGS RLE bitmap decoder: accept, evaluate, remainder wait, commit.
// Depends on prbd_pkg for the command and status structs.
`default_nettype none

module prbd_ctrl
    import prbd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire prbd_sts_t sts,
    output prbd_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MODW,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    assign s_ready = s_ready_reg;

    always_comb begin
        state_next    = state_reg;
        s_ready_next  = s_ready_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load     = 1'b1;
                    state_next   = ST_EVAL;
                    s_ready_next = 1'b0;
                end
            end
            ST_EVAL: begin
                if (sts.eol) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MODW;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_MODW: begin
                if (!sts.mod_busy) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold while a pending result would overwrite an untaken one
                if (!(sts.have && sts.out_busy)) begin
                    cmd.commit   = 1'b1;
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/prbd_colmod.sv -----
// Column remainder unit: pixel count modulo bitmap width, restoring, MOD_STEPS bits a cycle.
// Depends on prbd_pkg for widths and pass count.
`default_nettype none

module prbd_colmod
    import prbd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [PT_W-1:0]  dividend,
    input  wire logic [DIM_W-1:0] divisor,
    output logic                  busy,
    output logic [DIM_W-1:0]      remainder
);

    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MOD_DIV_W-1:0] sh_reg, sh_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

    always_comb begin
        logic [DIM_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < MOD_STEPS; i++) begin
            r = {r[DIM_W-1:0], sh_reg[MOD_DIV_W-1-i]};
            if (r >= {1'b0, divisor}) begin
                r = r - {1'b0, divisor};
            end
        end
        cnt_next = cnt_reg;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        if (start) begin
            cnt_next = MOD_CNT_W'(MOD_PASSES);
            sh_next  = MOD_DIV_W'(dividend);
            rem_next = '0;
        end else if (busy) begin
            cnt_next = cnt_reg - MOD_CNT_W'(1);
            sh_next  = sh_reg << MOD_STEPS;
            rem_next = r[DIM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

// ----- src/prbd_dpath.sv -----
// Datapath of the PGS RLE bitmap decoder: config registers, code parser, counters, result register.
// Depends on prbd_pkg and instantiates prbd_colmod.
`default_nettype none

module prbd_dpath
    import prbd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic [7:0]           s_data_byte,
    input  wire logic                 s_last_byte,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic                      m_run_valid,
    output logic [7:0]                m_pixel_color,
    output logic [RUN_W-1:0]          m_run_length,
    output logic [IDX_W-1:0]          m_start_index,
    output logic                      m_line_end,
    output logic                      m_line_short,
    output logic                      m_finished,
    output logic [1:0]                m_status,
    input  wire prbd_cmd_t            cmd,
    output prbd_sts_t                 sts
);

    typedef enum logic [1:0] {
        PH_COLOUR,
        PH_FLAGS,
        PH_RUNLOW,
        PH_RUNCOLOUR
    } phase_t;

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic             strict_reg;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [PT_W-1:0]  area_reg;
    logic [2*DIM_W-1:0] area_prod;

    // accepted byte
    logic [7:0] byte_reg;
    logic       last_reg;

    // decode state
    phase_t           phase_reg, phase_next;
    logic [7:0]       flags_reg, flags_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [PT_W-1:0]  pt_reg, pt_next;
    logic [DIM_W-1:0] lines_reg, lines_next;
    logic             halted_reg, halted_next;

    // parse results for the current byte
    logic             active, done;
    logic [7:0]       colour;
    logic [RUN_W-1:0] run;
    phase_t           dec_phase;
    logic [7:0]       dec_flags;
    logic [RUN_W-1:0] dec_run;
    logic [PT_W:0]    pt_sum;
    logic             fits, emit, eol, col_nz, strict_hit, halted_new;
    logic             lt_sum, lt_old, short_data;
    logic             r_line_short, r_line_end, r_finished, have;
    logic [1:0]       r_status;

    logic             mod_busy;
    logic [DIM_W-1:0] column;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic             o_run_valid_reg, o_line_end_reg, o_line_short_reg, o_finished_reg;
    logic [7:0]       o_color_reg;
    logic [RUN_W-1:0] o_length_reg;
    logic [IDX_W-1:0] o_start_reg;
    logic [1:0]       o_status_reg;

    assign w_eff     = clamp_dim(width_reg, MAX_WIDTH);
    assign h_eff     = clamp_dim(height_reg, MAX_HEIGHT);
    assign area_prod = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            strict_reg <= 1'b0;
            area_reg   <= PT_W'(1);
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_STRICT: strict_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
            area_reg <= area_prod[PT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_data_byte;
            last_reg <= s_last_byte;
        end
    end

    // code parser
    always_comb begin
        done      = 1'b0;
        colour    = '0;
        run       = '0;
        dec_phase = phase_reg;
        dec_flags = flags_reg;
        dec_run   = run_reg;
        case (phase_reg)
            PH_COLOUR: begin
                if (byte_reg != '0) begin
                    colour = byte_reg;
                    run    = RUN_W'(1);
                    done   = 1'b1;
                end else begin
                    dec_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                dec_flags = byte_reg;
                dec_run   = RUN_W'(byte_reg[SHORT_RUN_W-1:0]);
                if (byte_reg[FLAG_LONG_BIT]) begin
                    dec_phase = PH_RUNLOW;
                end else if (byte_reg[FLAG_COLOUR_BIT]) begin
                    dec_phase = PH_RUNCOLOUR;
                end else begin
                    run  = dec_run;
                    done = 1'b1;
                end
            end
            PH_RUNLOW: begin
                dec_run = {run_reg[RUN_W-9:0], byte_reg};
                if (flags_reg[FLAG_COLOUR_BIT]) begin
                    dec_phase = PH_RUNCOLOUR;
                end else begin
                    run  = dec_run;
                    done = 1'b1;
                end
            end
            PH_RUNCOLOUR: begin
                run    = run_reg;
                colour = byte_reg;
                done   = 1'b1;
            end
            default: begin
                dec_phase = PH_COLOUR;
            end
        endcase
    end

    assign active     = !halted_reg && (lines_reg < h_eff);
    assign pt_sum     = {1'b0, pt_reg} + (PT_W+1)'(run);
    assign fits       = (pt_sum <= {1'b0, area_reg});
    assign emit       = active && done && (run != '0) && fits;
    assign eol        = active && done && (run == '0);
    assign col_nz     = (column != '0);
    assign strict_hit = eol && col_nz && strict_reg;
    assign halted_new = halted_reg || strict_hit;

    // pixel shortfall after this byte, both outcomes compared in parallel
    assign lt_sum     = (pt_sum < {1'b0, area_reg});
    assign lt_old     = (pt_reg < area_reg);
    assign short_data = emit ? lt_sum : lt_old;

    assign r_line_short = eol && col_nz;
    assign r_line_end   = eol && !halted_new;
    assign r_finished   = strict_hit || (last_reg && !halted_new);
    assign have         = emit || r_line_short || r_line_end || r_finished;

    always_comb begin
        if (strict_hit) begin
            r_status = STATUS_LINE_ERR;
        end else if (r_finished && short_data) begin
            r_status = STATUS_SHORT_DATA;
        end else begin
            r_status = STATUS_OK;
        end
    end

    prbd_colmod u_colmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (pt_reg),
        .divisor   (w_eff),
        .busy      (mod_busy),
        .remainder (column)
    );

    always_comb begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        run_next    = run_reg;
        pt_next     = pt_reg;
        lines_next  = lines_reg;
        halted_next = halted_reg;
        if (cmd.commit) begin
            if (active) begin
                phase_next = dec_phase;
                flags_next = dec_flags;
                run_next   = dec_run;
                if (done) begin
                    phase_next = PH_COLOUR;
                    flags_next = '0;
                    run_next   = '0;
                end
                if (emit) begin
                    pt_next = pt_sum[PT_W-1:0];
                end
                if (r_line_end) begin
                    lines_next = lines_reg + DIM_W'(1);
                end
                halted_next = halted_new;
            end
            if (last_reg) begin
                // end of buffer: drop any partial code, ready for next bitmap
                phase_next  = PH_COLOUR;
                flags_next  = '0;
                run_next    = '0;
                pt_next     = '0;
                lines_next  = '0;
                halted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_COLOUR;
            flags_reg  <= '0;
            run_reg    <= '0;
            pt_reg     <= '0;
            lines_reg  <= '0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            run_reg    <= run_next;
            pt_reg     <= pt_next;
            lines_reg  <= lines_next;
            halted_reg <= halted_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit && have) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.commit && have) begin
            o_run_valid_reg  <= emit;
            o_color_reg      <= emit ? colour : 8'd0;
            o_length_reg     <= emit ? run : '0;
            o_start_reg      <= emit ? pt_reg[IDX_W-1:0] : '0;
            o_line_end_reg   <= r_line_end;
            o_line_short_reg <= r_line_short;
            o_finished_reg   <= r_finished;
            o_status_reg     <= r_status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_run_valid   = o_run_valid_reg;
    assign m_pixel_color = o_color_reg;
    assign m_run_length  = o_length_reg;
    assign m_start_index = o_start_reg;
    assign m_line_end    = o_line_end_reg;
    assign m_line_short  = o_line_short_reg;
    assign m_finished    = o_finished_reg;
    assign m_status      = o_status_reg;

    assign sts.eol      = eol;
    assign sts.mod_busy = mod_busy;
    assign sts.have     = have;
    assign sts.out_busy = m_valid_reg && !m_ready;

endmodule

`default_nettype wire

// ----- src/pgs_rle_bitmap_decoder.sv -----
// PGS RLE bitmap decoder: takes the compressed bitmap of one subtitle object one byte per
// request and returns pixel runs (colour, length, linear start index), end-of-line marks and
// an end-of-bitmap status. Set bitmap_width (index 0), bitmap_height (index 1) and
// strict_mode (index 2) on the cfg port while no byte is in flight; width and height are
// saturated to 1..4096. Each accepted byte passes evaluate and commit before the next byte
// is taken; one that closes an end-of-line code also waits in the remainder state while the
// column (pixel count modulo width) is computed by the remainder unit, 7 bits a cycle over
// the 25-bit count. A result that finds the output register still occupied waits in the
// commit state. The output register lets the next byte enter while the previous result
// is still offered. Runs that would overflow width*height are dropped. Mark the final byte
// with s_last_byte; its result carries finished and status 2 if too few pixels came. A
// partial code at the end is discarded and the decoder clears itself for the next bitmap.
// Depends on prbd_pkg, prbd_ctrl, prbd_dpath and prbd_colmod.
`default_nettype none

module pgs_rle_bitmap_decoder
    import prbd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,

    // compressed byte requests
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_data_byte,
    input  wire logic                 s_last_byte,

    // decoded results
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_run_valid,
    output logic [7:0]                m_pixel_color,
    output logic [RUN_W-1:0]          m_run_length,
    output logic [IDX_W-1:0]          m_start_index,
    output logic                      m_line_end,
    output logic                      m_line_short,
    output logic                      m_finished,
    output logic [1:0]                m_status
);

    prbd_cmd_t cmd;
    prbd_sts_t sts;

    // config registers are plain flops: always writable
    assign cfg_ready = 1'b1;

    // sequencer: accept -> evaluate -> (remainder wait) -> commit
    prbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // parser, pixel and line counters, remainder unit, result register
    prbd_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_run_valid   (m_run_valid),
        .m_pixel_color (m_pixel_color),
        .m_run_length  (m_run_length),
        .m_start_index (m_start_index),
        .m_line_end    (m_line_end),
        .m_line_short  (m_line_short),
        .m_finished    (m_finished),
        .m_status      (m_status),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

// ----- src/prbd_checker.sv -----
// Port-level checks on the PGS RLE bitmap decoder result channel, bound to the top level.
// Depends on prbd_pkg and pgs_rle_bitmap_decoder_assert.svh.
`default_nettype none

`include "pgs_rle_bitmap_decoder_assert.svh"

module prbd_checker
    import prbd_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic             m_run_valid,
    input wire logic [7:0]       m_pixel_color,
    input wire logic [RUN_W-1:0] m_run_length,
    input wire logic [IDX_W-1:0] m_start_index,
    input wire logic             m_line_end,
    input wire logic             m_line_short,
    input wire logic             m_finished,
    input wire logic [1:0]       m_status
);

    // stalled result holds
    `PRBD_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_run_valid) && $stable(m_pixel_color) && $stable(m_run_length) && $stable(m_start_index) && $stable(m_line_end) && $stable(m_line_short) && $stable(m_finished) && $stable(m_status))

    // status only carries meaning on the finishing result
    `PRBD_ASSERT_NOW(a_status_idle, m_valid && !m_finished, m_status == STATUS_OK)

    // run fields zero without a run, nonzero length with one
    `PRBD_ASSERT_NOW(a_run_fields, m_valid, m_run_valid ? (m_run_length != '0) : (m_run_length == '0 && m_pixel_color == '0 && m_start_index == '0))

    // strict abort: short line flagged, line not counted
    `PRBD_ASSERT_NOW(a_strict_abort, m_valid && m_status == STATUS_LINE_ERR, m_line_short && !m_line_end && m_finished && !m_run_valid)

endmodule

bind pgs_rle_bitmap_decoder prbd_checker u_prbd_checker (.*);

`default_nettype wire

// ----- verif/tb_pgs_rle_bitmap_decoder.sv -----
// Testbench for the PGS RLE bitmap decoder: drives compressed bitmap bytes and register
// writes, predicts every run, line mark and end status in a scoreboard class.
// Depends on prbd_pkg and pgs_rle_bitmap_decoder.
`timescale 1ns / 1ps

module tb_pgs_rle_bitmap_decoder;
    import prbd_pkg::*;

    // One decoded result, field order matches the m_ ports.
    typedef struct packed {
        logic             run_valid;
        logic [7:0]       color;
        logic [RUN_W-1:0] run_length;
        logic [IDX_W-1:0] start_index;
        logic             line_end;
        logic             line_short;
        logic             finished;
        logic [1:0]       status;
    } run_result_t;

    // Where the decoder stands inside an escape code.
    typedef enum logic [1:0] {
        PH_PIXEL,      // plain pixel byte or escape lead
        PH_FLAGS,      // flags byte after the zero lead
        PH_RUN_LOW,    // low 8 bits of a 14-bit run
        PH_RUN_COLOR   // trailing colour byte
    } code_phase_e;

    // Scoreboard: tracks decoder state, predicts results per request, checks them.
    class run_scoreboard;
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic              strict_reg;
        code_phase_e       phase;
        logic [7:0]        flags;
        logic [RUN_W-1:0]  held_run;
        longint unsigned   pixel_total;
        int unsigned       column;
        int unsigned       lines_done;
        bit                halted;
        run_result_t       runs_due[$];
        int                errors;

        function new();
            width_reg  = 1;
            height_reg = 1;
            strict_reg = 0;
            errors     = 0;
            clear_bitmap();
        endfunction

        function void clear_bitmap();
            phase       = PH_PIXEL;
            flags       = '0;
            held_run    = '0;
            pixel_total = 0;
            column      = 0;
            lines_done  = 0;
            halted      = 0;
        endfunction

        // Zero reads as 1, anything past the maximum as the maximum.
        function int unsigned eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] top);
            if (v == '0) begin
                return 1;
            end
            return 32'((v > top) ? top : v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_WIDTH:  width_reg  = val;
                CFG_HEIGHT: height_reg = val;
                CFG_STRICT: strict_reg = val[0];
                default: ;
            endcase
        endfunction

        // Decode one accepted byte; returns 1 unless the byte was ignored and was not the last.
        function bit note_request(logic [7:0] d, logic last);
            int unsigned     w;
            int unsigned     h;
            longint unsigned area;
            run_result_t     r;
            bit              have;
            bit              done;
            bit              used;
            logic [7:0]      colour;
            int unsigned     run_len;

            w       = eff_dim(width_reg, MAX_WIDTH);
            h       = eff_dim(height_reg, MAX_HEIGHT);
            area    = longint'(w) * longint'(h);
            r       = '0;
            have    = 0;
            done    = 0;
            colour  = '0;
            run_len = 0;
            used    = !halted && lines_done < h;

            if (used) begin
                case (phase)
                    PH_PIXEL: begin
                        if (d != 8'h00) begin
                            colour  = d;
                            run_len = 1;
                            done    = 1;
                        end else begin
                            phase = PH_FLAGS;
                        end
                    end
                    PH_FLAGS: begin
                        flags    = d;
                        held_run = RUN_W'(d[SHORT_RUN_W-1:0]);
                        if (d[FLAG_LONG_BIT]) begin
                            phase = PH_RUN_LOW;
                        end else if (d[FLAG_COLOUR_BIT]) begin
                            phase = PH_RUN_COLOR;
                        end else begin
                            run_len = 32'(held_run);
                            done    = 1;
                        end
                    end
                    PH_RUN_LOW: begin
                        held_run = {held_run[SHORT_RUN_W-1:0], d};
                        if (flags[FLAG_COLOUR_BIT]) begin
                            phase = PH_RUN_COLOR;
                        end else begin
                            run_len = 32'(held_run);
                            done    = 1;
                        end
                    end
                    default: begin
                        run_len = 32'(held_run);
                        colour  = d;
                        done    = 1;
                    end
                endcase

                if (done) begin
                    phase    = PH_PIXEL;
                    flags    = '0;
                    held_run = '0;
                    if (run_len > 0) begin
                        // runs past the end of the bitmap vanish silently
                        if (pixel_total + 64'(run_len) <= area) begin
                            r.run_valid   = 1;
                            r.color       = colour;
                            r.run_length  = RUN_W'(run_len);
                            r.start_index = pixel_total[IDX_W-1:0];
                            pixel_total  += 64'(run_len);
                            column        = 32'(pixel_total % 64'(w));
                            have          = 1;
                        end
                    end else begin
                        column = 32'(pixel_total % 64'(w));
                        if (column != 0) begin
                            r.line_short = 1;
                            have         = 1;
                            if (strict_reg) begin
                                r.finished = 1;
                                r.status   = STATUS_LINE_ERR;
                                halted     = 1;
                            end
                        end
                        if (!halted) begin
                            r.line_end = 1;
                            lines_done++;
                            have = 1;
                        end
                    end
                end
            end

            if (last) begin
                if (!halted) begin
                    r.finished = 1;
                    r.status   = (pixel_total < area) ? STATUS_SHORT_DATA : STATUS_OK;
                    have       = 1;
                end
                clear_bitmap();
            end

            if (have) begin
                runs_due.push_back(r);
            end
            return used || last;
        endfunction

        function bit differs(string what, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(run_result_t got);
            run_result_t e;
            bit          bad;

            if (runs_due.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, got %0h",
                         $time, got);
                errors++;
                return;
            end
            e   = runs_due.pop_front();
            bad = 0;
            bad |= differs("run_valid", 32'(e.run_valid), 32'(got.run_valid));
            bad |= differs("pixel_color", 32'(e.color), 32'(got.color));
            bad |= differs("run_length", 32'(e.run_length), 32'(got.run_length));
            bad |= differs("start_index", 32'(e.start_index), 32'(got.start_index));
            bad |= differs("line_end", 32'(e.line_end), 32'(got.line_end));
            bad |= differs("line_short", 32'(e.line_short), 32'(got.line_short));
            bad |= differs("finished", 32'(e.finished), 32'(got.finished));
            bad |= differs("status", 32'(e.status), 32'(got.status));
            if (bad) begin
                errors++;
            end
        endfunction
    endclass

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #4 aclk = ~aclk;

    // Block inputs, all known from time zero
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [DIM_W-1:0]     cfg_data    = '0;
    logic                 s_valid     = 1'b0;
    logic [7:0]           s_data_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 m_ready     = 1'b0;

    // Block outputs
    logic             cfg_ready;
    logic             s_ready;
    logic             m_valid;
    logic             m_run_valid;
    logic [7:0]       m_pixel_color;
    logic [RUN_W-1:0] m_run_length;
    logic [IDX_W-1:0] m_start_index;
    logic             m_line_end;
    logic             m_line_short;
    logic             m_finished;
    logic [1:0]       m_status;

    pgs_rle_bitmap_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_run_valid   (m_run_valid),
        .m_pixel_color (m_pixel_color),
        .m_run_length  (m_run_length),
        .m_start_index (m_start_index),
        .m_line_end    (m_line_end),
        .m_line_short  (m_line_short),
        .m_finished    (m_finished),
        .m_status      (m_status)
    );

    run_scoreboard sb;

    int items_done = 0;   // requests the decoder actually consumed
    bit calm       = 0;   // closing stretch: no gaps, no stalls
    int gap_pct    = 0;   // chance of an input gap before a request
    int stall_pct  = 0;   // chance of starting an output stall
    int stall_left = 0;

    // Result side: sample before this edge's updates land, then pick next ready.
    // Stalls come in bursts whose length is drawn when each stall starts.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_run_valid, m_pixel_color, m_run_length, m_start_index,
                             m_line_end, m_line_short, m_finished, m_status});
        end
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One register write; cfg_valid is left high so back-to-back writes never
    // lower and raise it in the same step. Caller drops it afterwards.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // One byte request. Optional gap first; valid held until accepted.
    task automatic send_byte(logic [7:0] d, logic last);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_request(d, last)) begin
            items_done++;
        end
    endtask

    // Let every expected result arrive, then give a byte that makes no result
    // time to clear the block (end-of-line takes the longest).
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.runs_due.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Encode one run (len 0 = end of line) in a randomly chosen legal form.
    function automatic void push_run(ref logic [7:0] q[$], input int unsigned len,
                                     input logic [7:0] colour);
        bit         tint;
        logic [7:0] fl;

        tint = (colour != 8'h00) || ($urandom_range(0, 1) == 1);
        if (len == 1 && colour != 8'h00 && $urandom_range(0, 1) == 1) begin
            q.push_back(colour);
            return;
        end
        q.push_back(8'h00);
        if (len < 64 && $urandom_range(0, 2) != 0) begin
            fl                  = 8'(len);
            fl[FLAG_COLOUR_BIT] = tint;
            q.push_back(fl);
        end else begin
            fl                  = 8'(len >> 8);
            fl[FLAG_LONG_BIT]   = 1'b1;
            fl[FLAG_COLOUR_BIT] = tint;
            q.push_back(fl);
            q.push_back(8'(len));
        end
        if (tint) begin
            q.push_back(colour);
        end
    endfunction

    // One bitmap: mostly well-formed lines at the current size with random
    // content, plus short lines, oversize runs, stray bytes and cut-off codes.
    task automatic send_bitmap(bit terminate);
        logic [7:0]  q[$];
        int unsigned w;
        int unsigned h;
        int unsigned lines;
        int unsigned remaining;
        int unsigned len;
        int          n;

        w         = sb.eff_dim(sb.width_reg, MAX_WIDTH);
        h         = sb.eff_dim(sb.height_reg, MAX_HEIGHT);
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);

        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 30)) q.push_back(8'($urandom));
        end else begin
            // tall bitmaps get only a few lines and end short
            lines = (h <= 8) ? h : $urandom_range(1, 8);
            if ($urandom_range(0, 5) == 0) begin
                lines++;   // one line past the height, ignored
            end
            repeat (lines) begin
                remaining = w;
                while (remaining > 0) begin
                    n = $urandom_range(0, 39);
                    if (n == 0) begin
                        break;   // line ends early
                    end
                    if (n == 1) begin
                        len = 16383;
                    end else if ($urandom_range(0, 2) == 0) begin
                        len = $urandom_range(1, remaining);
                    end else begin
                        len = $urandom_range(1, (remaining < 6) ? remaining : 6);
                    end
                    if (n == 2) begin
                        q.push_back(8'($urandom));
                    end
                    push_run(q, len, 8'($urandom));
                    remaining = (len >= remaining) ? 0 : remaining - len;
                end
                push_run(q, 0, 8'($urandom));
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
            end
            // code cut short by the end of the buffer
            case ($urandom_range(0, 7))
                0: q.push_back(8'h00);
                1: begin
                    q.push_back(8'h00);
                    q.push_back(8'(8'h40 | $urandom_range(0, 63)));
                end
                2: begin
                    q.push_back(8'h00);
                    q.push_back(8'(8'h80 | $urandom_range(0, 63)));
                end
                3: begin
                    q.push_back(8'h00);
                    q.push_back(8'(8'hc0 | $urandom_range(0, 63)));
                    q.push_back(8'($urandom));
                end
                default: ;
            endcase
        end
        foreach (q[i]) begin
            send_byte(q[i], terminate && (i == q.size() - 1));
        end
    endtask

    // New size/mode between bitmaps; each register written with odds 2 in 3.
    task automatic setup_phase();
        logic [DIM_W-1:0] wv;
        logic [DIM_W-1:0] hv;
        logic [DIM_W-1:0] sv;
        int               kind;

        kind = $urandom_range(0, 9);
        sv   = DIM_W'($urandom);   // only bit 0 counts
        case (kind)
            0: begin
                // full register range, saturation, huge area
                wv = DIM_W'($urandom);
                hv = DIM_W'($urandom);
            end
            1: begin
                case ($urandom_range(0, 4))
                    0: wv = '0;
                    1: wv = DIM_W'(1);
                    2: wv = DIM_W'(4095);
                    3: wv = MAX_WIDTH;
                    default: wv = '1;
                endcase
                hv = DIM_W'($urandom_range(1, 4));
            end
            default: begin
                wv = DIM_W'($urandom_range(1, 40));
                hv = DIM_W'($urandom_range(1, 6));
            end
        endcase
        if ($urandom_range(0, 2) != 0) write_reg(CFG_WIDTH, wv);
        if ($urandom_range(0, 2) != 0) write_reg(CFG_HEIGHT, hv);
        if ($urandom_range(0, 2) != 0) write_reg(CFG_STRICT, sv);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_list(logic [7:0] bytes[$], bit terminate);
        foreach (bytes[i]) begin
            send_byte(bytes[i], terminate && (i == bytes.size() - 1));
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, 4x2 lenient: pixel bytes at both ends of the range, long run
        // without colour, clean end of line, short run with colour, long run with
        // colour, run past the bitmap end (dropped), lenient short line which also
        // reaches the height, a byte after that (ignored), last byte with too
        // few pixels.
        gap_pct   = 20;
        stall_pct = 20;
        write_reg(CFG_WIDTH, DIM_W'(4));
        write_reg(CFG_HEIGHT, DIM_W'(2));
        write_reg(CFG_STRICT, DIM_W'(0));
        cfg_valid <= 1'b0;
        send_list('{8'h01, 8'hff, 8'h00, 8'h40, 8'h02, 8'h00, 8'h00,
                    8'h00, 8'h81, 8'h7f, 8'h00, 8'hc0, 8'h02, 8'h55,
                    8'h00, 8'h3f, 8'h00, 8'h00, 8'h07, 8'h00}, 1);
        drain();

        // Directed, width all ones (saturates to max), height zero (reads as 1),
        // strict: largest 14-bit run overflows, one pixel, short line aborts,
        // last byte then ignored while halted.
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, '0);
        write_reg(CFG_STRICT, DIM_W'(1));
        cfg_valid <= 1'b0;
        send_list('{8'h00, 8'h7f, 8'hff, 8'h05, 8'h00, 8'h00, 8'h09}, 1);
        items_done = 0;

        // Random phases until enough consumed requests; the tail runs flat out.
        while (items_done < 2000) begin
            drain();
            setup_phase();
            repeat ($urandom_range(1, 3)) begin
                calm = (items_done >= 1700);
                // now and then leave a bitmap open across a register change
                send_bitmap($urandom_range(0, 7) != 0);
            end
        end
        drain();

        if (sb.errors == 0 && sb.runs_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: reports TB_ERROR and ends the simulation if it is still running at the timeout.
    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
